[rtl/battery_power_mode_controller_assert.svh]
// Assertion macros shared by the battery power-mode controller RTL.
// Each macro expects signals named clk and arst_n in the including module.
`ifndef BATTERY_POWER_MODE_CONTROLLER_ASSERT_SVH
`define BATTERY_POWER_MODE_CONTROLLER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPMC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BPMC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/bpmc_pkg.sv]
// Package for the battery power-mode controller: request and mode codes,
// register indexes, fixed thresholds and the request, config and result types.
// Used by bpmc_core and battery_power_mode_controller.
package bpmc_pkg;

	localparam logic [2:0] REQ_TICK       = 3'd0;
	localparam logic [2:0] REQ_BUS_RX     = 3'd1;
	localparam logic [2:0] REQ_WINDOW_END = 3'd2;
	localparam logic [2:0] REQ_RTC_WAKE   = 3'd3;
	localparam logic [2:0] REQ_PREP_SLEEP = 3'd4;

	localparam logic [1:0] MODE_ACTIVE = 2'd0;
	localparam logic [1:0] MODE_RTC    = 2'd1;
	localparam logic [1:0] MODE_DEEP   = 2'd2;

	localparam logic [1:0] CFG_DEADBAND        = 2'd0;
	localparam logic [1:0] CFG_IDLE_SECONDS    = 2'd1;
	localparam logic [1:0] CFG_PERIOD_ACTIVE   = 2'd2;
	localparam logic [1:0] CFG_PERIOD_INACTIVE = 2'd3;

	localparam logic [7:0]  NO_ACK_INACTIVE_LIMIT = 8'd6;
	localparam logic [7:0]  NO_ACK_MAX            = 8'd255;
	localparam logic [1:0]  RTC_BUSINESS_FRAMES   = 2'd2;
	localparam logic [1:0]  RTC_PROBE_FRAMES      = 2'd2;
	localparam logic [15:0] DEEP_LOW_CELL_MV      = 16'd2600;
	localparam logic [31:0] DEEP_CONFIRM_MS       = 32'd60000;
	localparam logic [9:0]  MS_PER_S              = 10'd1000;

	typedef struct packed {
		logic [2:0]  req_type;
		logic        tx_acked;
		logic [15:0] charge_current;
		logic [15:0] discharge_current;
		logic        comm_active;
		logic        wake_asserted;
		logic        fault_present;
		logic [15:0] min_cell_mv;
		logic [15:0] delta_ms;
	} item_t;

	typedef struct packed {
		logic [15:0] current_deadband;
		logic [15:0] idle_seconds_before_rtc;
		logic [15:0] rtc_period_bus_active;
		logic [15:0] rtc_period_bus_inactive;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  power_mode;
		logic        rtc_req;
		logic        deep_req;
		logic        bus_alive;
		logic [15:0] rtc_period_s;
		logic [7:0]  unacked_windows;
	} result_t;

endpackage

[rtl/bpmc_core.sv]
// State and next-state logic of the battery power-mode controller.
// Applies one request per step and reports the state it leaves behind.
// Depends on bpmc_pkg and battery_power_mode_controller_assert.svh.
`include "battery_power_mode_controller_assert.svh"

module bpmc_core
	import bpmc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t result
);

	logic        bus_q, bus_d;
	logic [7:0]  no_ack_q, no_ack_d;
	logic [1:0]  business_q, business_d;
	logic [1:0]  probe_q, probe_d;
	logic [31:0] lv_timer_q, lv_timer_d;
	logic [31:0] idle_timer_q, idle_timer_d;
	logic [1:0]  mode_q, mode_d;
	logic        rtc_flag_q, rtc_flag_d;
	logic        deep_flag_q, deep_flag_d;

	logic        current_flowing;
	logic        blocker;
	logic        low_voltage;
	logic [31:0] lv_sum;
	logic [31:0] idle_sum;
	logic [25:0] idle_threshold;
	logic [7:0]  no_ack_inc;

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [15:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {17'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	assign current_flowing = (item.charge_current >= cfg.current_deadband) ||
		(item.discharge_current >= cfg.current_deadband);
	assign blocker = current_flowing || item.comm_active || item.wake_asserted ||
		item.fault_present || (business_q != 2'd0) || (probe_q != 2'd0);
	assign low_voltage = (item.min_cell_mv != 16'd0) &&
		(item.min_cell_mv <= DEEP_LOW_CELL_MV) &&
		(item.charge_current < cfg.current_deadband);
	assign lv_sum = sat_add(lv_timer_q, item.delta_ms);
	assign idle_sum = sat_add(idle_timer_q, item.delta_ms);
	assign idle_threshold = {10'b0, cfg.idle_seconds_before_rtc} * {16'b0, MS_PER_S};
	assign no_ack_inc = (no_ack_q < NO_ACK_MAX) ? no_ack_q + 8'd1 : no_ack_q;

	always_comb begin
		bus_d        = bus_q;
		no_ack_d     = no_ack_q;
		business_d   = business_q;
		probe_d      = probe_q;
		lv_timer_d   = lv_timer_q;
		idle_timer_d = idle_timer_q;
		mode_d       = mode_q;
		rtc_flag_d   = rtc_flag_q;
		deep_flag_d  = deep_flag_q;
		unique case (item.req_type)
			REQ_TICK: begin
				rtc_flag_d  = 1'b0;
				deep_flag_d = 1'b0;
				lv_timer_d  = low_voltage ? lv_sum : 32'd0;
				if (low_voltage && (lv_sum >= DEEP_CONFIRM_MS)) begin
					deep_flag_d = 1'b1;
					mode_d      = MODE_DEEP;
				end else if (blocker) begin
					idle_timer_d = 32'd0;
					mode_d       = MODE_ACTIVE;
				end else begin
					idle_timer_d = idle_sum;
					if (idle_sum >= {6'b0, idle_threshold}) begin
						rtc_flag_d = 1'b1;
						mode_d     = MODE_RTC;
					end else begin
						mode_d = MODE_ACTIVE;
					end
				end
			end
			REQ_BUS_RX: begin
				bus_d    = 1'b1;
				no_ack_d = 8'd0;
			end
			REQ_WINDOW_END: begin
				business_d = 2'd0;
				probe_d    = 2'd0;
				if (item.tx_acked) begin
					bus_d    = 1'b1;
					no_ack_d = 8'd0;
				end else begin
					no_ack_d = no_ack_inc;
					if (no_ack_inc >= NO_ACK_INACTIVE_LIMIT) begin
						bus_d = 1'b0;
					end
				end
			end
			REQ_RTC_WAKE: begin
				business_d = bus_q ? RTC_BUSINESS_FRAMES : 2'd0;
				probe_d    = bus_q ? 2'd0 : RTC_PROBE_FRAMES;
			end
			REQ_PREP_SLEEP: begin
				business_d = 2'd0;
				probe_d    = 2'd0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_q        <= 1'b1;
			no_ack_q     <= 8'd0;
			business_q   <= 2'd0;
			probe_q      <= 2'd0;
			lv_timer_q   <= 32'd0;
			idle_timer_q <= 32'd0;
			mode_q       <= MODE_ACTIVE;
			rtc_flag_q   <= 1'b0;
			deep_flag_q  <= 1'b0;
		end else if (step) begin
			bus_q        <= bus_d;
			no_ack_q     <= no_ack_d;
			business_q   <= business_d;
			probe_q      <= probe_d;
			lv_timer_q   <= lv_timer_d;
			idle_timer_q <= idle_timer_d;
			mode_q       <= mode_d;
			rtc_flag_q   <= rtc_flag_d;
			deep_flag_q  <= deep_flag_d;
		end
	end

	assign result.power_mode      = mode_d;
	assign result.rtc_req         = rtc_flag_d;
	assign result.deep_req        = deep_flag_d;
	assign result.bus_alive       = bus_d;
	assign result.rtc_period_s    = bus_d ? cfg.rtc_period_bus_active :
		cfg.rtc_period_bus_inactive;
	assign result.unacked_windows = no_ack_d;

	`BPMC_ASSERT_SAME(a_deep_mode, deep_flag_q, mode_q == MODE_DEEP,
		"deep request without deep mode")
	`BPMC_ASSERT_SAME(a_rtc_mode, rtc_flag_q, mode_q == MODE_RTC,
		"rtc request without rtc mode")
	`BPMC_ASSERT_SAME(a_bus_dead_count, !bus_q, no_ack_q >= NO_ACK_INACTIVE_LIMIT,
		"bus marked dead below the no-ack limit")
	`BPMC_ASSERT_SAME(a_frames_exclusive, business_q != 2'd0, probe_q == 2'd0,
		"business and probe frames pending together")
	`BPMC_ASSERT_NEXT(a_idle_hold, !step, $stable(idle_timer_q) && $stable(mode_q),
		"state changed without a request")

endmodule

[rtl/battery_power_mode_controller.sv]
// Battery power-mode controller: takes one event request per cycle and returns one
// result per request through the input register and then the result register.
// The next-state logic is one short pass between the two registers, so the rate is
// one request per cycle for as long as the result side keeps taking results.
// Configuration registers are written through the cfg port, which is always ready.
// Depends on bpmc_pkg and bpmc_core.
module battery_power_mode_controller
	import bpmc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  req_type,
	input  logic        tx_acked,
	input  logic [15:0] charge_current,
	input  logic [15:0] discharge_current,
	input  logic        comm_active,
	input  logic        wake_asserted,
	input  logic        fault_present,
	input  logic [15:0] min_cell_mv,
	input  logic [15:0] delta_ms,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  power_mode,
	output logic        rtc_req,
	output logic        deep_req,
	output logic        bus_alive,
	output logic [15:0] rtc_period_s,
	output logic [7:0]  unacked_windows
);

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    valid_s1;
	result_t result_q;
	logic    out_valid_q;
	result_t result_next;
	logic    advance;
	logic    out_free;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;
	assign advance   = valid_s1 && out_free;
	assign in_ready  = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_DEADBAND:        cfg_q.current_deadband        <= cfg_data;
				CFG_IDLE_SECONDS:    cfg_q.idle_seconds_before_rtc <= cfg_data;
				CFG_PERIOD_ACTIVE:   cfg_q.rtc_period_bus_active   <= cfg_data;
				CFG_PERIOD_INACTIVE: cfg_q.rtc_period_bus_inactive <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.req_type          <= req_type;
			item_s1.tx_acked          <= tx_acked;
			item_s1.charge_current    <= charge_current;
			item_s1.discharge_current <= discharge_current;
			item_s1.comm_active       <= comm_active;
			item_s1.wake_asserted     <= wake_asserted;
			item_s1.fault_present     <= fault_present;
			item_s1.min_cell_mv       <= min_cell_mv;
			item_s1.delta_ms          <= delta_ms;
		end
		if (advance) begin
			result_q <= result_next;
		end
	end

	bpmc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (result_next)
	);

	assign out_valid       = out_valid_q;
	assign power_mode      = result_q.power_mode;
	assign rtc_req         = result_q.rtc_req;
	assign deep_req        = result_q.deep_req;
	assign bus_alive       = result_q.bus_alive;
	assign rtc_period_s    = result_q.rtc_period_s;
	assign unacked_windows = result_q.unacked_windows;

endmodule
